[hw/rtl/nfd_pkg.sv]
// nfd_pkg: shared types, control codes and the microcode ROM of the
// noise-floor denoiser. No dependencies; used by the datapath and the top level.

package nfd_pkg;

  // Configuration register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SMOOTHING = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_REDUCTION = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_WET_MIX   = 2'd3;

  // Multiplier operand A select
  localparam logic [1:0] MA_ALPHA  = 2'd0;
  localparam logic [1:0] MA_IALPHA = 2'd1;
  localparam logic [1:0] MA_GAIN   = 2'd2;
  localparam logic [1:0] MA_MIX    = 2'd3;

  // Multiplier operand B select
  localparam logic [1:0] MB_FLOOR = 2'd0;
  localparam logic [1:0] MB_MAG   = 2'd1;
  localparam logic [1:0] MB_TRIM  = 2'd2;

  // Datapath operations
  localparam logic [2:0] OP_NONE     = 3'd0;
  localparam logic [2:0] OP_LOAD_ACC = 3'd1;
  localparam logic [2:0] OP_UPD_NF   = 3'd2;
  localparam logic [2:0] OP_LOAD_T   = 3'd3;
  localparam logic [2:0] OP_EMIT     = 3'd4;

  // Sequencer jump kinds
  localparam logic [1:0] JMP_NEXT     = 2'd0;
  localparam logic [1:0] JMP_WAIT_IN  = 2'd1;
  localparam logic [1:0] JMP_IF_LOUD  = 2'd2;
  localparam logic [1:0] JMP_WAIT_OUT = 2'd3;

  // Program steps
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_DECAY  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_NEW    = 3'd2;
  localparam logic [STEP_W-1:0] STEP_UPDATE = 3'd3;
  localparam logic [STEP_W-1:0] STEP_GAIN   = 3'd4;
  localparam logic [STEP_W-1:0] STEP_TRIM   = 3'd5;
  localparam logic [STEP_W-1:0] STEP_MIX    = 3'd6;
  localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd7;

  typedef struct packed {
    logic [1:0]        a_sel;
    logic [1:0]        b_sel;
    logic [2:0]        op;
    logic [1:0]        jmp;
    logic [STEP_W-1:0] target;
  } ucw_t;

  // Control handed from the sequencer to the datapath
  typedef struct packed {
    logic       load_in;
    logic [1:0] a_sel;
    logic [1:0] b_sel;
    logic [2:0] op;
  } dp_ctrl_t;

  // Status handed back from the datapath
  typedef struct packed {
    logic below;
  } dp_stat_t;

  // Microcode ROM: one control word per step
  function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
    ucw_t w;
    w = '{a_sel: MA_ALPHA, b_sel: MB_FLOOR, op: OP_NONE, jmp: JMP_NEXT, target: STEP_IDLE};
    case (step)
      STEP_IDLE: begin
        w.jmp = JMP_WAIT_IN;
      end
      STEP_DECAY: begin
        // alpha * floor; loud samples skip the estimate update
        w.jmp    = JMP_IF_LOUD;
        w.target = STEP_GAIN;
      end
      STEP_NEW: begin
        w.a_sel = MA_IALPHA;
        w.b_sel = MB_MAG;
        w.op    = OP_LOAD_ACC;
      end
      STEP_UPDATE: begin
        w.op = OP_UPD_NF;
      end
      STEP_GAIN: begin
        w.a_sel = MA_GAIN;
      end
      STEP_TRIM: begin
        w.op = OP_LOAD_T;
      end
      STEP_MIX: begin
        w.a_sel = MA_MIX;
        w.b_sel = MB_TRIM;
      end
      STEP_EMIT: begin
        // operands held so the product stays put while the output waits
        w.a_sel  = MA_MIX;
        w.b_sel  = MB_TRIM;
        w.op     = OP_EMIT;
        w.jmp    = JMP_WAIT_OUT;
        w.target = STEP_IDLE;
      end
      default: begin
        w.jmp    = JMP_NEXT;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/nfd_datapath.sv]
// nfd_datapath: sample registers, one shared multiplier, noise floor and
// blend/saturate logic, steered by the sequencer. Depends on nfd_pkg.

module nfd_datapath #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  nfd_pkg::dp_ctrl_t           ctrl,
  input  logic [SAMPLE_BITS-1:0]      sample_in,
  input  logic [SAMPLE_BITS-2:0]      threshold,
  input  logic [COEF_FRAC_BITS-1:0]   alpha,
  input  logic [COEF_FRAC_BITS:0]     gain,
  input  logic [COEF_FRAC_BITS:0]     mix,
  output nfd_pkg::dp_stat_t           stat,
  output logic [SAMPLE_BITS-1:0]      sample_y,
  output logic [SAMPLE_BITS-2:0]      noise_floor
);

  localparam int S   = SAMPLE_BITS;
  localparam int F   = COEF_FRAC_BITS;
  localparam int M   = S - 1;
  localparam int A_W = F + 1;
  localparam int P_W = A_W + S;
  localparam int Y_W = S + 3;

  localparam logic [A_W-1:0] ONE_A   = {1'b1, {F{1'b0}}};
  localparam logic [P_W:0]   RND     = {{(P_W + 1 - F){1'b0}}, {F{1'b1}}};
  localparam logic [Y_W-1:0] Y_MAX   = {{(Y_W - M){1'b0}}, {M{1'b1}}};
  localparam logic [Y_W-1:0] Y_MIN   = {{(Y_W - M){1'b1}}, {M{1'b0}}};
  localparam logic [S-1:0]   SAT_POS = {1'b0, {M{1'b1}}};
  localparam logic [S-1:0]   SAT_NEG = {1'b1, {M{1'b0}}};

  logic [S-1:0]   x_r;
  logic [S-1:0]   mag_r;
  logic [P_W-1:0] prod_r;
  logic [P_W-1:0] acc_r;
  logic [M-1:0]   nf_r;
  logic [S-1:0]   trim_r;

  logic [A_W-1:0] op_a;
  logic [S-1:0]   op_b;
  logic [P_W:0]   blend_sum;
  logic [P_W:0]   rnd_up;
  logic           x_pos;
  logic           x_neg;
  logic [Y_W-1:0] adj;
  logic [Y_W-1:0] y_wide;

  // Shared multiplier operand selection
  always_comb begin
    case (ctrl.a_sel)
      nfd_pkg::MA_ALPHA:  op_a = {1'b0, alpha};
      nfd_pkg::MA_IALPHA: op_a = ONE_A - {1'b0, alpha};
      nfd_pkg::MA_GAIN:   op_a = gain;
      nfd_pkg::MA_MIX:    op_a = mix;
      default:            op_a = '0;
    endcase
    case (ctrl.b_sel)
      nfd_pkg::MB_FLOOR: op_b = {1'b0, nf_r};
      nfd_pkg::MB_MAG:   op_b = mag_r;
      nfd_pkg::MB_TRIM:  op_b = trim_r;
      default:           op_b = '0;
    endcase
  end

  assign blend_sum = {1'b0, acc_r} + {1'b0, prod_r};

  // Product, accumulator, trim amount and input sample
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (ctrl.load_in) begin
      x_r   <= sample_in;
      // two's complement magnitude; the most negative code gives 2^(S-1)
      mag_r <= sample_in[S-1] ? (~sample_in + 1'b1) : sample_in;
    end
    if (ctrl.op == nfd_pkg::OP_LOAD_ACC) begin
      acc_r <= prod_r;
    end
    if (ctrl.op == nfd_pkg::OP_LOAD_T) begin
      trim_r <= prod_r[F +: S];
    end
  end

  // Noise floor estimate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nf_r <= '0;
    end else if (ctrl.op == nfd_pkg::OP_UPD_NF) begin
      nf_r <= blend_sum[F +: M];
    end
  end

  assign stat.below  = mag_r < {1'b0, threshold};
  assign noise_floor = nf_r;

  // Blend: positive x moves down by ceil(mix*t), negative x up by floor(mix*t)
  assign rnd_up = {1'b0, prod_r} + RND;
  assign x_pos  = !x_r[S-1] && (|x_r);
  assign x_neg  = x_r[S-1];

  always_comb begin
    if (x_pos) begin
      adj = '0 - {1'b0, rnd_up[P_W:F]};
    end else if (x_neg) begin
      adj = {2'b00, prod_r[P_W-1:F]};
    end else begin
      adj = '0;
    end
  end

  assign y_wide = {{3{x_r[S-1]}}, x_r} + adj;

  // Saturate to the sample range
  always_comb begin
    if ($signed(y_wide) > $signed(Y_MAX)) begin
      sample_y = SAT_POS;
    end else if ($signed(y_wide) < $signed(Y_MIN)) begin
      sample_y = SAT_NEG;
    end else begin
      sample_y = y_wide[S-1:0];
    end
  end

endmodule

[hw/rtl/noise_floor_denoiser_core.sv]
// noise_floor_denoiser_core: top level; configuration registers, microcode
// sequencer and output register. Depends on nfd_pkg and nfd_datapath.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall   in_sample_in
//   out       output     out_valid / out_stall out_sample_out, out_noise_level
//   cfg       input      cfg_we                cfg_index, cfg_data
//
// A sample passes the idle step that takes its transfer, then the steps decay,
// new, update, gain, trim, mix and emit, where its result is offered. A sample
// at or above the threshold skips the estimate update (new and update). The
// single shared multiplier takes one operand pair per step.
// Reset (synchronous, rst_n low) loads register defaults, clears the noise
// floor and returns the sequencer to its idle step.
// The output register holds a result until taken; if it is still full at the
// last step, the sequencer waits there and does not take new input.

module noise_floor_denoiser_core #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 16,
  localparam int CFG_W = (SAMPLE_BITS - 1 > COEF_FRAC_BITS + 1) ?
                         SAMPLE_BITS - 1 : COEF_FRAC_BITS + 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [SAMPLE_BITS-1:0]          in_sample_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [SAMPLE_BITS-1:0]          out_sample_out,
  output logic [SAMPLE_BITS-2:0]          out_noise_level,
  input  logic                            cfg_we,
  input  logic [nfd_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]                cfg_data
);

  localparam int M  = SAMPLE_BITS - 1;
  localparam int F  = COEF_FRAC_BITS;
  localparam int GW = F + 1;

  logic [M-1:0]  thr_r;
  logic [F-1:0]  alpha_r;
  logic [GW-1:0] gain_r;
  logic [GW-1:0] mix_r;

  logic [nfd_pkg::STEP_W-1:0] step_r;
  logic [nfd_pkg::STEP_W-1:0] step_nxt;
  nfd_pkg::ucw_t              cw;
  nfd_pkg::dp_ctrl_t          dp_ctrl;
  nfd_pkg::dp_stat_t          dp_stat;

  logic                   in_xfer;
  logic                   slot_free;
  logic                   emit;
  logic [SAMPLE_BITS-1:0] y_val;
  logic [M-1:0]           nf_val;

  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_sample_r;
  logic [M-1:0]           out_noise_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= M'(8389);
      alpha_r <= F'(65522);
      gain_r  <= GW'(65536);
      mix_r   <= GW'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        nfd_pkg::REG_THRESHOLD: thr_r   <= cfg_data[M-1:0];
        nfd_pkg::REG_SMOOTHING: alpha_r <= cfg_data[F-1:0];
        nfd_pkg::REG_REDUCTION: gain_r  <= cfg_data[GW-1:0];
        nfd_pkg::REG_WET_MIX:   mix_r   <= cfg_data[GW-1:0];
        default: ;
      endcase
    end
  end

  // Microcode fetch and handshakes
  assign cw        = nfd_pkg::ucode(step_r);
  assign in_stall  = (cw.jmp != nfd_pkg::JMP_WAIT_IN);
  assign in_xfer   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign emit      = (cw.op == nfd_pkg::OP_EMIT) && slot_free;

  // Next step
  always_comb begin
    case (cw.jmp)
      nfd_pkg::JMP_NEXT:     step_nxt = step_r + 1'b1;
      nfd_pkg::JMP_WAIT_IN:  step_nxt = in_xfer ? step_r + 1'b1 : step_r;
      nfd_pkg::JMP_IF_LOUD:  step_nxt = dp_stat.below ? step_r + 1'b1 : cw.target;
      nfd_pkg::JMP_WAIT_OUT: step_nxt = slot_free ? cw.target : step_r;
      default:               step_nxt = nfd_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= nfd_pkg::STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign dp_ctrl.load_in = in_xfer;
  assign dp_ctrl.a_sel   = cw.a_sel;
  assign dp_ctrl.b_sel   = cw.b_sel;
  assign dp_ctrl.op      = cw.op;

  nfd_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (dp_ctrl),
    .sample_in   (in_sample_in),
    .threshold   (thr_r),
    .alpha       (alpha_r),
    .gain        (gain_r),
    .mix         (mix_r),
    .stat        (dp_stat),
    .sample_y    (y_val),
    .noise_floor (nf_val)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_sample_r <= y_val;
      out_noise_r  <= nf_val;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_sample_r;
  assign out_noise_level = out_noise_r;

endmodule

[hw/rtl/nfd_checker.sv]
// nfd_checker: port-level assertions for noise_floor_denoiser_core, attached
// by the bind statement below. Needs only the top level's ports.

module nfd_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [SAMPLE_BITS-1:0] out_sample_out,
  input logic [SAMPLE_BITS-2:0] out_noise_level
);

  // One sample in flight: a transfer closes the input until its work is done
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken on two consecutive cycles");

  // A new result only appears while the input side was closed
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while input was open");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_sample_out) && $stable(out_noise_level)))
    else $error("stalled result payload changed");

endmodule

bind noise_floor_denoiser_core nfd_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_nfd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_sample_out  (out_sample_out),
  .out_noise_level (out_noise_level)
);

[test/noise_floor_denoiser_core_test.sv]
// noise_floor_denoiser_core_test: self-checking testbench for the noise-floor denoiser core.
// Drives samples and register writes, predicts every result and compares it field by field.
// Depends on nfd_pkg and noise_floor_denoiser_core.
`timescale 1ns / 1ps

module noise_floor_denoiser_core_test;

  localparam int          SMP_W        = 24;
  localparam int          CFG_W        = 23;
  localparam longint      COEF_ONE     = 65536;
  localparam longint      SMP_MAX      = 8388607;
  localparam longint      SMP_MIN      = -8388608;
  localparam int unsigned CFG_MAX      = 23'h7FFFFF;
  localparam int unsigned GAIN_MAX     = 17'h1FFFF;
  localparam int unsigned ALPHA_MAX    = 16'hFFFF;
  localparam int          RANDOM_ITEMS = 120;
  localparam int          MAX_REPORTS  = 100;

  // one denoised output sample
  typedef struct {
    logic [SMP_W-1:0] smp;
    logic [SMP_W-2:0] level;
  } denoised_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [SMP_W-1:0]             in_sample_in = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [SMP_W-1:0]             out_sample_out;
  logic [SMP_W-2:0]             out_noise_level;
  logic                         cfg_we = 1'b0;
  logic [nfd_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]             cfg_data = '0;

  // predictor copy of the registers and the noise floor
  logic [22:0] thr_q   = 23'd8389;
  logic [15:0] alpha_q = 16'd65522;
  logic [16:0] gain_q  = 17'd65536;
  logic [16:0] mix_q   = 17'd65536;
  logic [22:0] floor_q = '0;

  denoised_t   pending_q[$];
  int          mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          hold_request = 0;
  int          hold_left = 0;

  noise_floor_denoiser_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_in    (in_sample_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample_out  (out_sample_out),
    .out_noise_level (out_noise_level),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Noise floor update, subtraction and dry/wet blend for one sample
  function automatic denoised_t denoise_sample(input logic [SMP_W-1:0] smp);
    longint    x = longint'($signed(smp));
    longint    mag;
    longint    acc;
    longint    trim;
    longint    diff;
    longint    y;
    denoised_t res;
    mag = (x < 0) ? -x : x;
    if (mag < longint'(thr_q)) begin
      acc = longint'(alpha_q) * longint'(floor_q) + (COEF_ONE - longint'(alpha_q)) * mag;
      floor_q = 23'(acc >> 16);
    end
    trim = (longint'(gain_q) * longint'(floor_q)) >> 16;
    if (x > 0) diff = -trim;
    else if (x < 0) diff = trim;
    else diff = 0;
    // arithmetic shift rounds toward minus infinity
    y = x + ((longint'(mix_q) * diff) >>> 16);
    if (y > SMP_MAX) y = SMP_MAX;
    if (y < SMP_MIN) y = SMP_MIN;
    res.smp   = y[SMP_W-1:0];
    res.level = floor_q;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_count < MAX_REPORTS)
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // One input transfer; the expectation is queued at the accepting edge
  task automatic send_sample(input logic [SMP_W-1:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= smp;
    do @(posedge clk); while (in_stall);
    pending_q.push_back(denoise_sample(smp));
  endtask

  // Drop valid, drain all results, then give the core time to settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Write all four registers on back-to-back cycles while idle
  task automatic load_coefficients(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] alpha,
                                   input logic [CFG_W-1:0] gain, input logic [CFG_W-1:0] mix);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= nfd_pkg::REG_THRESHOLD;
    cfg_data <= thr;
    @(posedge clk);
    thr_q = thr[22:0];
    cfg_index <= nfd_pkg::REG_SMOOTHING;
    cfg_data <= alpha;
    @(posedge clk);
    alpha_q = alpha[15:0];
    cfg_index <= nfd_pkg::REG_REDUCTION;
    cfg_data <= gain;
    @(posedge clk);
    gain_q = gain[16:0];
    cfg_index <= nfd_pkg::REG_WET_MIX;
    cfg_data <= mix;
    @(posedge clk);
    mix_q = mix[16:0];
    cfg_we <= 1'b0;
  endtask

  // Mostly quiet samples that train the floor, plus loud, full-range and edge values
  function automatic logic [SMP_W-1:0] random_sample();
    int unsigned      pick = $urandom_range(99);
    logic [SMP_W-1:0] mag;
    logic [SMP_W-1:0] smp;
    if (pick < 45) begin
      mag = (thr_q == 0) ? '0 : SMP_W'($urandom_range(int'(thr_q) - 1));
      smp = $urandom_range(1) ? -mag : mag;
    end else if (pick < 75) begin
      smp = SMP_W'($urandom);
    end else if (pick < 88) begin
      case ($urandom_range(7))
        0: smp = '0;
        1: smp = 24'd1;
        2: smp = 24'hFFFFFF;
        3: smp = 24'h7FFFFF;
        4: smp = 24'h800000;
        5: smp = {1'b0, thr_q};
        6: smp = -{1'b0, thr_q};
        default: smp = {1'b0, thr_q} - 1'b1;
      endcase
    end else begin
      mag = SMP_W'($urandom_range(255));
      smp = $urandom_range(1) ? -mag : mag;
    end
    return smp;
  endfunction

  // Receiver: random stalls, plus a counted hold-off on request
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare each result transfer with the oldest pending expectation
  always @(posedge clk) begin : check_results
    denoised_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        report_mismatch("result with nothing pending", longint'($signed(out_sample_out)), 0);
      end else begin
        want = pending_q.pop_front();
        if (out_sample_out !== want.smp)
          report_mismatch("sample_out", longint'($signed(out_sample_out)),
                          longint'($signed(want.smp)));
        if (out_noise_level !== want.level)
          report_mismatch("noise_level", longint'(out_noise_level), longint'(want.level));
      end
    end
  end

  // Default registers, sign and range edges
  task automatic test_reset_defaults();
    send_sample(24'd0);
    send_sample(24'd1);
    send_sample(24'hFFFFFF);
    send_sample(24'd100);
    send_sample(-24'd5000);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
  endtask

  // Register extremes: gain and mix above 1.0, sign inversion, saturation, bypass
  task automatic test_config_extremes();
    load_coefficients(CFG_W'(SMP_MAX), '0, CFG_W'(GAIN_MAX), CFG_W'(GAIN_MAX));
    send_sample(24'd1000000);
    send_sample(24'hFFFFFF);     // floor follows |x|: output pulled to zero
    send_sample(24'd3);
    send_sample(24'd0);
    send_sample(24'h800000);     // most negative input is never below threshold
    send_sample(24'h7FFFFF);
    send_sample(-24'd4000000);   // pushed past full scale, saturates high
    send_sample(24'd4000000);    // saturates low
    load_coefficients('0, CFG_W'(ALPHA_MAX), '0, '0);
    send_sample(24'd12345);
    send_sample(-24'd12345);
    send_sample(24'h7FFFFF);
  endtask

  // Random samples over four idle profiles and four register settings each
  task automatic test_random_traffic();
    int unsigned idle_send[4] = '{0, 75, 0, 8};
    int unsigned idle_recv[4] = '{0, 0, 75, 8};
    for (int ph = 0; ph < 4; ph++) begin
      for (int setting = 0; setting < 4; setting++) begin
        case (setting)
          0: load_coefficients(CFG_W'($urandom_range(CFG_MAX)), CFG_W'($urandom_range(CFG_MAX)),
                               CFG_W'($urandom_range(CFG_MAX)), CFG_W'($urandom_range(CFG_MAX)));
          1: load_coefficients(CFG_W'(SMP_MAX), CFG_W'($urandom_range(ALPHA_MAX)),
                               CFG_W'(GAIN_MAX), CFG_W'(GAIN_MAX));
          2: load_coefficients(CFG_W'($urandom_range(65535)), '0,
                               CFG_W'($urandom_range(GAIN_MAX)), CFG_W'(COEF_ONE));
          default: load_coefficients(CFG_W'($urandom_range(1 << 20)),
                                     CFG_W'($urandom_range(ALPHA_MAX, 60000)),
                                     CFG_W'(COEF_ONE), CFG_W'($urandom_range(65536)));
        endcase
        send_idle_pct  = idle_send[ph];
        recv_stall_pct = idle_recv[ph];
        repeat (RANDOM_ITEMS) send_sample(random_sample());
      end
    end
  endtask

  // Long receiver hold-off while samples keep coming, so the input stalls
  task automatic test_output_backpressure();
    load_coefficients(CFG_W'($urandom_range(1 << 20)), CFG_W'($urandom_range(ALPHA_MAX)),
                      CFG_W'(COEF_ONE), CFG_W'(COEF_ONE));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 300;
    repeat (16) send_sample(random_sample());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_config_extremes();
    test_random_traffic();
    test_output_backpressure();
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
